// ----- src/number_to_glyph_rows_macros.svh -----
// Assertion macros shared by the number_to_glyph_rows modules.
`ifndef NUMBER_TO_GLYPH_ROWS_MACROS_SVH
`define NUMBER_TO_GLYPH_ROWS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NTG_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ntg: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NTG_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ntg: next-cycle check failed");

`endif

// ----- src/ntg_pkg.sv -----
// Types, constants and helpers shared by the number_to_glyph_rows modules.
package ntg_pkg;

    localparam int NUM_W     = 63;
    localparam int BIT_CNT_W = 6;
    localparam int PIX_W     = 38;
    localparam int CNT_W     = 5;
    localparam int ROW_W     = 2;
    localparam int FONT_W    = 20;
    localparam int FONT_ROWS = 4;
    localparam int ADDR_W    = 4;

    localparam logic [FONT_W-1:0] FONT_RESET [FONT_ROWS] = '{
        20'd1044475, 20'd825263, 20'd752283, 20'd491259
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_COUNT,
        ST_EMIT
    } ntg_state_t;

    typedef struct packed {
        logic             load;
        logic             shift;
        logic             count_en;
        logic             emit;
        logic [ROW_W-1:0] row;
        logic             last;
    } ntg_cmd_t;

    typedef struct packed {
        logic out_free;
    } ntg_sts_t;

    // Two cells of digit d in one font row; left cell in bit 0.
    function automatic logic [1:0] glyph_cells(input logic [FONT_W-1:0] row_bits,
                                               input logic [3:0] d);
        logic [FONT_W-1:0] sh;
        sh = row_bits >> {d, 1'b0};
        return sh[1:0];
    endfunction

endpackage

// ----- src/ntg_regs.sv -----
// APB register file holding the four font rows.
module ntg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ntg_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [ntg_pkg::FONT_W-1:0]  font_rows [ntg_pkg::FONT_ROWS]
);

    logic [ntg_pkg::FONT_W-1:0] font_reg [ntg_pkg::FONT_ROWS];
    logic                       wr_en;
    logic [1:0]                 sel;

    assign pready = 1'b1;
    assign sel    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign prdata = 32'(font_reg[sel]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            font_reg <= ntg_pkg::FONT_RESET;
        end else if (wr_en) begin
            font_reg[sel] <= pwdata[ntg_pkg::FONT_W-1:0];
        end
    end

    assign font_rows = font_reg;

endmodule

// ----- src/ntg_ctrl.sv -----
// Sequencer: conversion bit counter, digit count step and row emission.
`include "number_to_glyph_rows_macros.svh"

module ntg_ctrl #(
    parameter int GLYPH_ROWS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ntg_pkg::ntg_sts_t sts,
    output ntg_pkg::ntg_cmd_t cmd
);

    localparam logic [ntg_pkg::BIT_CNT_W-1:0] BIT_LAST = ntg_pkg::BIT_CNT_W'(ntg_pkg::NUM_W - 1);
    localparam logic [ntg_pkg::ROW_W-1:0]     ROW_LAST = ntg_pkg::ROW_W'(GLYPH_ROWS - 1);

    ntg_pkg::ntg_state_t             state_reg, state_next;
    logic [ntg_pkg::BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [ntg_pkg::ROW_W-1:0]       row_reg, row_next;
    logic                            in_accept;
    logic                            emit_go;

    assign s_tready  = (state_reg == ntg_pkg::ST_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign emit_go   = (state_reg == ntg_pkg::ST_EMIT) & sts.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ntg_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            row_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            row_reg     <= row_next;
        end
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        row_next     = row_reg;
        case (state_reg)
            ntg_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next   = ntg_pkg::ST_CONVERT;
                    bit_cnt_next = '0;
                end
            end
            ntg_pkg::ST_CONVERT: begin
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_LAST) begin
                    state_next = ntg_pkg::ST_COUNT;
                end
            end
            ntg_pkg::ST_COUNT: begin
                state_next = ntg_pkg::ST_EMIT;
                row_next   = '0;
            end
            ntg_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    row_next = row_reg + 1'b1;
                    if (row_reg == ROW_LAST) begin
                        state_next = ntg_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ntg_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        cmd.load     = in_accept;
        cmd.shift    = (state_reg == ntg_pkg::ST_CONVERT);
        cmd.count_en = (state_reg == ntg_pkg::ST_COUNT);
        cmd.emit     = emit_go;
        cmd.row      = row_reg;
        cmd.last     = (row_reg == ROW_LAST);
    end

    `NTG_ASSERT_NXT(a_accept_starts_convert, aclk, aresetn,
                    in_accept, (state_reg == ntg_pkg::ST_CONVERT) && (bit_cnt_reg == '0))
    `NTG_ASSERT_NXT(a_last_row_frees_input, aclk, aresetn,
                    emit_go && (row_reg == ROW_LAST), s_tready)
    `NTG_ASSERT_IMP(a_count_after_full_convert, aclk, aresetn,
                    (state_reg == ntg_pkg::ST_COUNT), $past(bit_cnt_reg) == BIT_LAST)

endmodule

// ----- src/ntg_dpath.sv -----
// Datapath: shift-add-3 decimal conversion, digit count and row rendering.
`include "number_to_glyph_rows_macros.svh"

module ntg_dpath #(
    parameter int MAX_DIGITS = 19
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ntg_pkg::NUM_W-1:0]   in_number,
    input  logic [ntg_pkg::FONT_W-1:0]  font_rows [ntg_pkg::FONT_ROWS],
    input  ntg_pkg::ntg_cmd_t           cmd,
    output ntg_pkg::ntg_sts_t           sts,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [ntg_pkg::ROW_W-1:0]   out_row,
    output logic [ntg_pkg::PIX_W-1:0]   out_pixels,
    output logic [ntg_pkg::CNT_W-1:0]   out_count,
    output logic                        out_last
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int REV_W = 2 * MAX_DIGITS;
    localparam logic [ntg_pkg::CNT_W-1:0] MAX_C = ntg_pkg::CNT_W'(MAX_DIGITS);

    logic [ntg_pkg::NUM_W-1:0]  num_reg;
    logic [BCD_W-1:0]           bcd_reg;
    logic [BCD_W-1:0]           bcd_corr;
    logic                       ovf_reg;
    logic [ntg_pkg::CNT_W-1:0]  count_reg;
    logic [ntg_pkg::CNT_W-1:0]  count_next;
    logic [REV_W-1:0]           rev_pix;
    logic [ntg_pkg::FONT_W-1:0] row_font;
    logic [ntg_pkg::CNT_W:0]    shamt;
    logic [ntg_pkg::PIX_W-1:0]  pix_next;

    logic                       out_valid_reg;
    logic [ntg_pkg::ROW_W-1:0]  out_row_reg;
    logic [ntg_pkg::PIX_W-1:0]  out_pix_reg;
    logic [ntg_pkg::CNT_W-1:0]  out_cnt_reg;
    logic                       out_last_reg;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            bcd_corr[4*k +: 4] = (bcd_reg[4*k +: 4] >= 4'd5) ? bcd_reg[4*k +: 4] + 4'd3
                                                              : bcd_reg[4*k +: 4];
        end
    end

    // highest non-zero digit; a carry out of the top digit pins the count
    always_comb begin
        count_next = ntg_pkg::CNT_W'(1);
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (bcd_reg[4*k +: 4] != 4'd0) begin
                count_next = ntg_pkg::CNT_W'(k + 1);
            end
        end
        if (ovf_reg) begin
            count_next = MAX_C;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            num_reg <= in_number;
            bcd_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.shift) begin
            num_reg <= num_reg << 1;
            bcd_reg <= {bcd_corr[BCD_W-2:0], num_reg[ntg_pkg::NUM_W-1]};
            ovf_reg <= ovf_reg | bcd_corr[BCD_W-1];
        end
        if (cmd.count_en) begin
            count_reg <= count_next;
        end
    end

    // digits placed most significant first, then aligned to the digit count
    assign row_font = font_rows[cmd.row];
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            rev_pix[2*(MAX_DIGITS-1-k) +: 2] = ntg_pkg::glyph_cells(row_font,
                                                                    bcd_reg[4*k +: 4]);
        end
    end
    assign shamt    = {MAX_C - count_reg, 1'b0};
    assign pix_next = ntg_pkg::PIX_W'(rev_pix) >> shamt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_row_reg  <= cmd.row;
            out_pix_reg  <= pix_next;
            out_cnt_reg  <= count_reg;
            out_last_reg <= cmd.last;
        end
    end

    assign sts.out_free = ~out_valid_reg | m_tready;
    assign m_tvalid     = out_valid_reg;
    assign out_row      = out_row_reg;
    assign out_pixels   = out_pix_reg;
    assign out_count    = out_cnt_reg;
    assign out_last     = out_last_reg;

    `NTG_ASSERT_NXT(a_count_in_range, aclk, aresetn,
                    cmd.count_en, (count_reg != '0) && (count_reg <= MAX_C))
    `NTG_ASSERT_IMP(a_emit_only_when_free, aclk, aresetn,
                    cmd.emit, sts.out_free)

endmodule

// ----- src/number_to_glyph_rows.sv -----
// Top level of number_to_glyph_rows: renders a number as rows of 2x4 digit glyphs.
//
// Input channel s_*: one request carries a 63-bit unsigned number in s_tdata.
// Output channel m_*: four requests per number, one per glyph row, top row
// first. m_tuser is the row index, m_tlast marks the final row, m_tdata holds
// the row's pixel mask (bit 2j+c, digit j from the left, cell c) and the count
// of decimal digits. Font rows are set through the APB port at 0x0..0xC and
// must only be written while the block is idle.
// Sequence: the number is taken, converted to decimal by a shift-add-3 loop
// (one input bit per cycle), the digit count is found in its own state, then
// one row is loaded into the output register per cycle while that register
// is free. The input is taken again once the last row is in the output
// register, so the next conversion runs while that row still waits.
// Stalls on m_tready hold the output register and pause row emission.
// Reset (aresetn low, synchronous) empties the output and loads the default
// font.
module number_to_glyph_rows #(
    parameter int MAX_DIGITS = 19,
    parameter int GLYPH_ROWS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // [62:0] number
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,   // [37:0] row_pixels, [42:38] digit_count
    output logic [ntg_pkg::ROW_W-1:0]   m_tuser,   // row_index
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ntg_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [ntg_pkg::FONT_W-1:0] font_rows [ntg_pkg::FONT_ROWS];
    ntg_pkg::ntg_cmd_t          cmd;
    ntg_pkg::ntg_sts_t          sts;
    logic [ntg_pkg::PIX_W-1:0]  out_pixels;
    logic [ntg_pkg::CNT_W-1:0]  out_count;

    ntg_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .font_rows (font_rows)
    );

    ntg_ctrl #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ntg_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_number  (s_tdata[ntg_pkg::NUM_W-1:0]),
        .font_rows  (font_rows),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_row    (m_tuser),
        .out_pixels (out_pixels),
        .out_count  (out_count),
        .out_last   (m_tlast)
    );

    assign m_tdata = {5'd0, out_count, out_pixels};

endmodule

// ----- bench/testbench.sv -----
// Testbench for number_to_glyph_rows: random and directed numbers, font changes, row checks.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_DIGITS  = 19;
    localparam int GLYPH_ROWS  = 4;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam longint unsigned NUMBER_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam int FONT_ROW0 = 0;
    localparam int FONT_ROW1 = 1;
    localparam int FONT_ROW2 = 2;
    localparam int FONT_ROW3 = 3;

    typedef struct packed {
        logic [ntg_pkg::ROW_W-1:0] row_index;
        logic [ntg_pkg::PIX_W-1:0] row_pixels;
        logic [ntg_pkg::CNT_W-1:0] digit_count;
        logic                      last_row;
    } glyph_row_t;

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [63:0]                s_tdata  = '0;     // [62:0] number
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [47:0]                m_tdata;           // [37:0] row_pixels, [42:38] digit_count
    logic [ntg_pkg::ROW_W-1:0]  m_tuser;           // row_index
    logic                       m_tlast;
    logic                       psel     = 1'b0;
    logic                       penable  = 1'b0;
    logic                       pwrite   = 1'b0;
    logic [ntg_pkg::ADDR_W-1:0] paddr    = '0;
    logic [31:0]                pwdata   = '0;
    logic [31:0]                prdata;
    logic                       pready;

    logic [ntg_pkg::FONT_W-1:0] font_model [ntg_pkg::FONT_ROWS];
    logic [62:0]                pending_numbers [$];
    glyph_row_t                 expected_rows [$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int fail_count      = 0;
    int numbers_sent    = 0;
    int rows_checked    = 0;
    int font_settings   = 1;
    int cycle_count     = 0;

    number_to_glyph_rows #(
        .MAX_DIGITS (MAX_DIGITS),
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Splits the number into decimal digits and queues the four glyph rows it should give.
    function automatic void render_number(input logic [62:0] number);
        longint unsigned           n;
        logic [3:0]                digits [20];
        int                        count;
        logic [1:0]                cells;
        logic [ntg_pkg::PIX_W-1:0] pixels;
        glyph_row_t                row;
        n = number;
        count = 0;
        do begin
            digits[count] = 4'(n % 10);
            count++;
            n = n / 10;
        end while (n != 0 && count < 20);
        if (count > MAX_DIGITS)
            count = MAX_DIGITS;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            pixels = '0;
            for (int j = 0; j < count; j++) begin
                cells = 2'(font_model[r] >> (2 * digits[count - 1 - j]));
                pixels |= ntg_pkg::PIX_W'(cells) << (2 * j);
            end
            row.row_index   = ntg_pkg::ROW_W'(r);
            row.row_pixels  = pixels;
            row.digit_count = ntg_pkg::CNT_W'(count);
            row.last_row    = (r == GLYPH_ROWS - 1);
            expected_rows.push_back(row);
        end
    endfunction

    // Bias towards every digit length; a quarter are plain 63-bit noise.
    function automatic logic [62:0] pick_number();
        longint unsigned lo, span, raw;
        int              len;
        raw = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            return raw[62:0];
        len = $urandom_range(1, 19);
        lo = 1;
        for (int k = 1; k < len; k++)
            lo = lo * 10;
        span = (len == 19) ? (NUMBER_MAX - lo + 1) : 9 * lo;
        return 63'(lo + raw % span);
    endfunction

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                render_number(s_tdata[62:0]);
                numbers_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_numbers.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, pending_numbers.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Row monitor
    always @(posedge aclk) begin : row_monitor
        glyph_row_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    $error("glyph row %0d arrived with nothing expected", m_tuser);
                    fail_count++;
                end else begin
                    want = expected_rows.pop_front();
                    rows_checked++;
                    if (m_tuser !== want.row_index) begin
                        $error("row_index: expected %0d, got %0d", want.row_index, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[37:0] !== want.row_pixels) begin
                        $error("row_pixels: expected %h, got %h", want.row_pixels,
                               m_tdata[37:0]);
                        fail_count++;
                    end
                    if (m_tdata[42:38] !== want.digit_count) begin
                        $error("digit_count: expected %0d, got %0d", want.digit_count,
                               m_tdata[42:38]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last_row) begin
                        $error("last_row: expected %0d, got %0d", want.last_row, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic font_write(input int row, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ntg_pkg::ADDR_W'(4 * row);
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the low 20 bits are kept
        font_model[row] = data[ntg_pkg::FONT_W-1:0];
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_numbers.size() != 0 || s_tvalid || expected_rows.size() != 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        @(negedge aclk);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (count) pending_numbers.push_back(pick_number());
        wait_drained();
    endtask

    task automatic load_font(input logic [31:0] r0, input logic [31:0] r1,
                             input logic [31:0] r2, input logic [31:0] r3);
        font_write(FONT_ROW0, r0);
        font_write(FONT_ROW1, r1);
        font_write(FONT_ROW2, r2);
        font_write(FONT_ROW3, r3);
        font_settings++;
    endtask

    initial begin
        for (int r = 0; r < ntg_pkg::FONT_ROWS; r++)
            font_model[r] = ntg_pkg::FONT_RESET[r];
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        pending_numbers.push_back(63'd0);
        pending_numbers.push_back(63'd1);
        pending_numbers.push_back(63'd9);
        pending_numbers.push_back(63'd10);
        pending_numbers.push_back(63'd42);
        pending_numbers.push_back(63'd99);
        pending_numbers.push_back(63'd100);
        pending_numbers.push_back(63'd1234567890);
        pending_numbers.push_back(63'd9876543210);
        pending_numbers.push_back(63'd4294967295);
        pending_numbers.push_back(63'd4294967296);
        pending_numbers.push_back(63'd999999999999999999);
        pending_numbers.push_back(63'd1000000000000000000);
        pending_numbers.push_back(63'd1111111111111111111);
        pending_numbers.push_back(63'd5555555555555555555);
        pending_numbers.push_back(63'd8888888888888888888);
        pending_numbers.push_back(63'h4000_0000_0000_0000);
        pending_numbers.push_back(63'(NUMBER_MAX));
        wait_drained();

        run_phase(0, 0, 60);

        load_font($urandom, $urandom, $urandom, $urandom);
        run_phase(54, 0, 90);

        load_font('0, '0, '0, '0);
        run_phase(0, 54, 60);

        // all ones, with junk above the register width
        load_font('1, '1, '1, '1);
        run_phase(28, 28, 60);

        load_font(32'h000A_AAAA, 32'hFFF5_5555, 32'h0005_5555, 32'h123A_AAAA);
        run_phase(0, 0, 80);

        load_font(32'(ntg_pkg::FONT_RESET[0]), 32'(ntg_pkg::FONT_RESET[1]),
                  32'(ntg_pkg::FONT_RESET[2]), 32'(ntg_pkg::FONT_RESET[3]));
        run_phase(28, 28, 100);

        repeat (20) @(posedge aclk);
        $display("%0d numbers rendered, %0d glyph rows checked under %0d font settings,",
                 numbers_sent, rows_checked, font_settings);
        $display("including zero, every digit length up to 19 and blank/solid fonts");
        if (fail_count == 0 && expected_rows.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

endmodule
